[rtl/ebsb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ebsb_pkg;

    localparam int WORD_W = 32;
    localparam int UNS_W  = 31;

    // Register indexes of the configuration space.
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MAX_X = 3'd2;
    localparam logic [2:0] REG_MAX_Y = 3'd3;
    localparam logic [2:0] REG_WRAP  = 3'd4;

    typedef struct packed {
        logic signed [WORD_W-1:0] force_x;
        logic signed [WORD_W-1:0] force_y;
        logic signed [WORD_W-1:0] vel_in_x;
        logic signed [WORD_W-1:0] vel_in_y;
        logic signed [WORD_W-1:0] pos_in_x;
        logic signed [WORD_W-1:0] pos_in_y;
        logic [UNS_W-1:0]         body_mass;
        logic [UNS_W-1:0]         friction_coef;
        logic [UNS_W-1:0]         delta_t;
    } body_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] vel_out_x;
        logic signed [WORD_W-1:0] vel_out_y;
        logic signed [WORD_W-1:0] pos_out_x;
        logic signed [WORD_W-1:0] pos_out_y;
    } body_rsp_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] min_x;
        logic signed [WORD_W-1:0] min_y;
        logic signed [WORD_W-1:0] max_x;
        logic signed [WORD_W-1:0] max_y;
        logic                     wrap;
    } bounds_t;

endpackage
`default_nettype wire

[rtl/ebsb_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider for |force| << FRAC_BITS / mass, one quotient bit
// per step. Steps are grouped by BITS_PER_STAGE between registers.
module ebsb_div #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int BITS_PER_STAGE = 4,
    parameter int TAG_W = 8
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   adv,
    input  wire                   in_valid,
    input  wire [WORD_WIDTH-1:0]  mag,
    input  wire [WORD_WIDTH-2:0]  divisor,
    input  wire [TAG_W-1:0]       in_tag,
    output logic                  out_valid,
    output logic [WORD_WIDTH+FRAC_BITS-1:0] quot,
    output logic [TAG_W-1:0]      out_tag
);
    localparam int NB = WORD_WIDTH + FRAC_BITS;
    localparam int NS = (NB + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int DW = WORD_WIDTH - 1;

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [NB-1:0]    num_in, num_next, num_reg;
        logic [DW:0]      rem_in, rem_next, rem_reg;
        logic [DW-1:0]    den_in, den_reg;
        logic [TAG_W-1:0] tag_in, tag_reg;
        logic             vld_in, vld_reg;

        if (s == 0)
        begin : g_first
            assign num_in = {mag, {FRAC_BITS{1'b0}}};
            assign rem_in = '0;
            assign den_in = divisor;
            assign tag_in = in_tag;
            assign vld_in = in_valid;
        end
        else
        begin : g_next
            assign num_in = g_stage[s-1].num_reg;
            assign rem_in = g_stage[s-1].rem_reg;
            assign den_in = g_stage[s-1].den_reg;
            assign tag_in = g_stage[s-1].tag_reg;
            assign vld_in = g_stage[s-1].vld_reg;
        end

        always_comb
        begin
            logic [DW+1:0] trial;
            num_next = num_in;
            rem_next = rem_in;
            trial    = '0;
            for (int b = 0; b < BITS_PER_STAGE; b++)
            begin
                // Steps past the last numerator bit leave the quotient alone.
                if (s * BITS_PER_STAGE + b < NB)
                begin
                    trial = {rem_next, num_next[NB-1]} - {2'b00, den_in};
                    if (!trial[DW+1])
                    begin
                        rem_next = trial[DW:0];
                        num_next = {num_next[NB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = {rem_next[DW-1:0], num_next[NB-1]};
                        num_next = {num_next[NB-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_reg <= num_next;
                rem_reg <= rem_next;
                den_reg <= den_in;
                tag_reg <= tag_in;
            end
        end
    end

    // After NB shifts the numerator register holds the quotient.
    assign quot      = g_stage[NS-1].num_reg;
    assign out_valid = g_stage[NS-1].vld_reg;
    assign out_tag   = g_stage[NS-1].tag_reg;
endmodule
`default_nettype wire

[rtl/ebsb_axis.sv]
`timescale 1ns / 1ps
`default_nettype none
// One axis: divide, then three multiply stages and the bounds check, each
// product registered before the next step.
module ebsb_axis #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          adv,
    input  wire                          in_valid,
    input  wire signed [WORD_WIDTH-1:0]  frc,
    input  wire signed [WORD_WIDTH-1:0]  vel,
    input  wire signed [WORD_WIDTH-1:0]  pos,
    input  wire [WORD_WIDTH-2:0]         mass,
    input  wire [WORD_WIDTH-2:0]         fric,
    input  wire [WORD_WIDTH-2:0]         dt,
    input  wire signed [WORD_WIDTH-1:0]  lo,
    input  wire signed [WORD_WIDTH-1:0]  hi,
    input  wire                          wrap,
    output logic                         out_valid,
    output logic signed [WORD_WIDTH-1:0] vel_o,
    output logic signed [WORD_WIDTH-1:0] pos_o
);
    localparam int W  = WORD_WIDTH;
    localparam int U  = WORD_WIDTH - 1;
    localparam int PW = 2 * W;
    localparam int TAG_W = 1 + 2 * W + 2 * U;
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat_p(input logic signed [PW+1:0] v);
        if (v > $signed({{(PW+2-W){1'b0}}, SMAX}))      return SMAX;
        else if (v < $signed({{(PW+2-W){1'b1}}, SMIN})) return SMIN;
        else                                            return v[W-1:0];
    endfunction

    // Floor shift of an exact product, then saturate.
    function automatic logic signed [W-1:0] shq(input logic signed [PW-1:0] p);
        logic signed [PW+1:0] e;
        e = {{2{p[PW-1]}}, p};
        return sat_p(e >>> FRAC_BITS);
    endfunction

    // Divider: magnitude of force, divisor at least one.
    logic [W-1:0] fmag;
    logic [U-1:0] mden;
    assign fmag = frc[W-1] ? W'(-frc) : W'(frc);
    assign mden = (mass == '0) ? U'(1) : mass;

    logic               dv;
    logic [W+FRAC_BITS-1:0] q;
    logic [TAG_W-1:0]   dtag;

    ebsb_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS), .TAG_W(TAG_W)) u_div (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid),
        .mag(fmag), .divisor(mden), .in_tag({frc[W-1], vel, pos, fric, dt}),
        .out_valid(dv), .quot(q), .out_tag(dtag)
    );

    logic             neg_d;
    logic signed [W-1:0] vel_d, pos_d;
    logic [U-1:0]     fr_d, dt_d;
    assign {neg_d, vel_d, pos_d, fr_d, dt_d} = dtag;

    logic signed [W-1:0] acc;
    always_comb
    begin
        logic signed [PW+1:0] qs;
        qs  = $signed({{(PW+2-W-FRAC_BITS){1'b0}}, q});
        acc = sat_p(neg_d ? -qs : qs);
    end

    // Stage A: a * dt.
    logic [4:0] v_reg;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [W-1:0]  va_vel_reg, vb_reg, vc_reg, pa_pos_reg, pb_pos_reg, pc_pos_reg;
    logic signed [W-1:0]  pd_reg, vd_reg;
    logic [U-1:0] ad_dt_reg, ad_fr_reg, bd_dt_reg;

    logic signed [W-1:0] v1, d2, v2, psum, pfin;
    always_comb
    begin
        logic signed [W-1:0]  a_dt, v1_fr, d_dt;
        logic signed [PW+1:0] t;
        a_dt  = shq(pa_reg);
        v1_fr = shq(pb_reg);
        d_dt  = shq(pc_reg);
        v1    = sat_p((PW+2)'(va_vel_reg) + (PW+2)'(a_dt));
        t     = (PW+2)'(v1_fr);
        d2    = sat_p(t + t);
        v2    = sat_p((PW+2)'(vc_reg) - (PW+2)'(d_dt));
        psum  = sat_p((PW+2)'(pc_pos_reg) + (PW+2)'(v2));
        if (pd_reg < lo) pfin = wrap ? hi : lo;
        else             pfin = pd_reg;
        if (pfin > hi)   pfin = wrap ? lo : hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[3:0], dv};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg     <= acc * $signed({1'b0, dt_d});
            va_vel_reg <= vel_d;
            pa_pos_reg <= pos_d;
            ad_dt_reg  <= dt_d;
            ad_fr_reg  <= fr_d;
            pb_reg     <= v1 * $signed({1'b0, ad_fr_reg});
            vb_reg     <= v1;
            pb_pos_reg <= pa_pos_reg;
            bd_dt_reg  <= ad_dt_reg;
            pc_reg     <= d2 * $signed({1'b0, bd_dt_reg});
            vc_reg     <= vb_reg;
            pc_pos_reg <= pb_pos_reg;
            pd_reg     <= psum;
            vd_reg     <= v2;
            vel_o      <= vd_reg;
            pos_o      <= pfin;
        end
    end
    assign out_valid = v_reg[4];
endmodule
`default_nettype wire

[rtl/euler_body_step_bounds.sv]
`timescale 1ns / 1ps
`default_nettype none
// One semi-implicit Euler step with friction and world bounds per body.
// Requests enter on in_valid/in_stall with payload in_data; results leave on
// out_valid/out_stall with payload out_data, one result per request, in order.
// A request is taken at any edge with in_valid high and in_stall low.
// A request passes through the divider, whose depth is the word width plus
// FRAC_BITS over four, rounded up, and then the multiply, saturate and
// bounds stages; the divider sets most of the depth.
// Throughput is one request per cycle while the output is not stalled.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises, so nothing is dropped or repeated.
// Reset clears all valid bits and the bound registers (zero bounds, clamp).
// Bounds are written over the APB port at byte addresses 0,4,8,12 and 16.
// Each axis clamps below the minimum first, then above the maximum.
module euler_body_step_bounds #(
    parameter int FRAC_BITS  = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire ebsb_pkg::body_req_t in_data,
    output logic                   out_valid,
    input  wire                    out_stall,
    output ebsb_pkg::body_rsp_t    out_data,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [4:0]              paddr,
    input  wire [31:0]             pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    ebsb_pkg::bounds_t bnd_reg;
    logic adv;
    logic vx, vy;
    logic signed [ebsb_pkg::WORD_W-1:0] nvx, nvy, npx, npy;

    assign pready = 1'b1;
    // The pipeline advances unless a finished result is held by the receiver.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                ebsb_pkg::REG_MIN_X: bnd_reg.min_x <= pwdata;
                ebsb_pkg::REG_MIN_Y: bnd_reg.min_y <= pwdata;
                ebsb_pkg::REG_MAX_X: bnd_reg.max_x <= pwdata;
                ebsb_pkg::REG_MAX_Y: bnd_reg.max_y <= pwdata;
                ebsb_pkg::REG_WRAP:  bnd_reg.wrap  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            ebsb_pkg::REG_MIN_X: prdata = bnd_reg.min_x;
            ebsb_pkg::REG_MIN_Y: prdata = bnd_reg.min_y;
            ebsb_pkg::REG_MAX_X: prdata = bnd_reg.max_x;
            ebsb_pkg::REG_MAX_Y: prdata = bnd_reg.max_y;
            ebsb_pkg::REG_WRAP:  prdata = {31'b0, bnd_reg.wrap};
            default:             prdata = '0;
        endcase
    end

    ebsb_axis #(.WORD_WIDTH(ebsb_pkg::WORD_W), .FRAC_BITS(FRAC_BITS)) u_x (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid),
        .frc(in_data.force_x), .vel(in_data.vel_in_x), .pos(in_data.pos_in_x),
        .mass(in_data.body_mass), .fric(in_data.friction_coef),
        .dt(in_data.delta_t), .lo(bnd_reg.min_x), .hi(bnd_reg.max_x),
        .wrap(bnd_reg.wrap), .out_valid(vx), .vel_o(nvx), .pos_o(npx)
    );

    ebsb_axis #(.WORD_WIDTH(ebsb_pkg::WORD_W), .FRAC_BITS(FRAC_BITS)) u_y (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid),
        .frc(in_data.force_y), .vel(in_data.vel_in_y), .pos(in_data.pos_in_y),
        .mass(in_data.body_mass), .fric(in_data.friction_coef),
        .dt(in_data.delta_t), .lo(bnd_reg.min_y), .hi(bnd_reg.max_y),
        .wrap(bnd_reg.wrap), .out_valid(vy), .vel_o(nvy), .pos_o(npy)
    );

    assign out_valid          = vx;
    assign out_data.vel_out_x = nvx;
    assign out_data.vel_out_y = nvy;
    assign out_data.pos_out_x = npx;
    assign out_data.pos_out_y = npy;

`ifndef SYNTH
    // Both axis pipelines carry the same valid pattern.
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n) vx == vy)
        else $error("axis valid mismatch");
    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    // Input is stalled exactly when the output is.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("stall mismatch");
`endif
endmodule
`default_nettype wire

[tb/sv/euler_body_step_bounds_test.sv]
`timescale 1ns / 1ps
module euler_body_step_bounds_test;

    localparam logic signed [63:0] WMAX = 64'sd2147483647;
    localparam logic signed [63:0] WMIN = -64'sd2147483648;
    // Margin for the block's pipeline to drain once the queues are empty.
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    ebsb_pkg::body_req_t in_data;
    logic out_valid;
    logic out_stall;
    ebsb_pkg::body_rsp_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    euler_body_step_bounds i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Our own copy of the world bounds, updated with every register write.
    logic signed [31:0] lim_min_x, lim_min_y, lim_max_x, lim_max_y;
    logic wrap_mode;

    ebsb_pkg::body_req_t pending_requests[$];
    ebsb_pkg::body_rsp_t expected_bodies[$];
    int mismatch_count = 0;
    bit quiet_mode = 1'b0;   // no idling on either side
    bit sender_hold = 1'b0;  // sender pauses while set
    bit in_accepted = 1'b0;  // a request was taken at the last rising edge

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturate to the signed 32-bit range.
    function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
        if (v > WMAX)
            return WMAX;
        if (v < WMIN)
            return WMIN;
        return v;
    endfunction

    // Q16.16 product, rounded toward minus infinity, then saturated.
    // The arithmetic shift of the exact product floors as required.
    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return clip32(p >>> 16);
    endfunction

    // Force over mass: magnitude divided, truncated toward zero, saturated.
    function automatic logic signed [63:0] qdiv(input logic signed [63:0] f,
                                                input logic [63:0] m);
        logic [63:0] mag;
        logic [63:0] q;
        if (m == 0)
            m = 1;
        mag = (f < 0) ? 64'(-f) : 64'(f);
        q = (mag << 16) / m;
        if (f < 0)
            return clip32(-$signed(q));
        return clip32($signed(q));
    endfunction

    // One axis of the Euler step, then the bound checks (min first, then max).
    function automatic void step_axis(input logic signed [63:0] f,
                                      input logic signed [63:0] v,
                                      input logic signed [63:0] p, input logic [63:0] m,
                                      input logic signed [63:0] fr,
                                      input logic signed [63:0] dt,
                                      input logic signed [63:0] lo,
                                      input logic signed [63:0] hi,
                                      output logic signed [31:0] vout,
                                      output logic signed [31:0] pout);
        logic signed [63:0] a, v1, d, np;
        a = qdiv(f, m);
        v1 = clip32(v + qmul(a, dt));
        d = qmul(v1, fr);
        d = clip32(d * 2);
        d = qmul(d, dt);
        v1 = clip32(v1 - d);
        np = clip32(p + v1);
        if (np < lo)
            np = wrap_mode ? hi : lo;
        if (np > hi)
            np = wrap_mode ? lo : hi;
        vout = v1[31:0];
        pout = np[31:0];
    endfunction

    function automatic ebsb_pkg::body_rsp_t predict_body(input ebsb_pkg::body_req_t r);
        ebsb_pkg::body_rsp_t e;
        logic signed [31:0] vx, vy, px, py;
        step_axis(64'(r.force_x), 64'(r.vel_in_x), 64'(r.pos_in_x), {33'd0, r.body_mass},
                  {33'd0, r.friction_coef}, {33'd0, r.delta_t},
                  64'(lim_min_x), 64'(lim_max_x), vx, px);
        step_axis(64'(r.force_y), 64'(r.vel_in_y), 64'(r.pos_in_y), {33'd0, r.body_mass},
                  {33'd0, r.friction_coef}, {33'd0, r.delta_t},
                  64'(lim_min_y), 64'(lim_max_y), vy, py);
        e.vel_out_x = vx;
        e.vel_out_y = vy;
        e.pos_out_x = px;
        e.pos_out_y = py;
        return e;
    endfunction

    // Random idling: with a chance of about 8 in a hundred, none in quiet stretches.
    function automatic bit idle_now();
        return !quiet_mode && ($urandom_range(99) < 8);
    endfunction

    // Request driver: changes inputs at the falling edge only.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_accepted)
            begin
                // The previous request, if any, was accepted at the last rising edge.
                if (pending_requests.size() > 0 && !sender_hold && !idle_now())
                begin
                    in_data <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= idle_now();
        end
    end

    // Predict on acceptance so the bound copy matches what the block uses.
    always @(posedge clk)
    begin
        in_accepted <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            expected_bodies = {expected_bodies, predict_body(in_data)};
    end

    // Result monitor: compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        ebsb_pkg::body_rsp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bodies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result %h", out_data);
            end
            else
            begin
                e = expected_bodies.pop_front();
                if (out_data.vel_out_x !== e.vel_out_x || out_data.vel_out_y !== e.vel_out_y
                    || out_data.pos_out_x !== e.pos_out_x
                    || out_data.pos_out_y !== e.pos_out_y)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Mismatch: expected v=(%0d,%0d) p=(%0d,%0d)",
                                 e.vel_out_x, e.vel_out_y, e.pos_out_x, e.pos_out_y);
                        $display("          got      v=(%0d,%0d) p=(%0d,%0d)",
                                 out_data.vel_out_x, out_data.vel_out_y,
                                 out_data.pos_out_x, out_data.pos_out_y);
                    end
                end
            end
        end
    end

    // Register write over APB: setup cycle then access cycle, then a read back.
    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        logic [31:0] expect_rd;
        expect_rd = (index == ebsb_pkg::REG_WRAP) ? {31'd0, value[0]} : value;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (prdata !== expect_rd || pready !== 1'b1)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Register %0d: expected %h got %h", index, expect_rd, prdata);
        end
        case (index)
            ebsb_pkg::REG_MIN_X: lim_min_x = value;
            ebsb_pkg::REG_MIN_Y: lim_min_y = value;
            ebsb_pkg::REG_MAX_X: lim_max_x = value;
            ebsb_pkg::REG_MAX_Y: lim_max_y = value;
            ebsb_pkg::REG_WRAP: wrap_mode = value[0];
            default: ;
        endcase
    endtask

    task automatic set_bounds(input logic [31:0] mnx, input logic [31:0] mny,
                              input logic [31:0] mxx, input logic [31:0] mxy,
                              input logic w);
        write_reg(ebsb_pkg::REG_MIN_X, mnx);
        write_reg(ebsb_pkg::REG_MIN_Y, mny);
        write_reg(ebsb_pkg::REG_MAX_X, mxx);
        write_reg(ebsb_pkg::REG_MAX_Y, mxy);
        write_reg(ebsb_pkg::REG_WRAP, {31'd0, w});
    endtask

    // Let every request drain so the block is idle before a register write.
    task automatic wait_idle();
        while (pending_requests.size() > 0 || in_valid || expected_bodies.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Values mostly of moderate size, so that results are not all saturated.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(3) == 0 ? 32'h7fffffff : 32'h80000000;
            2, 3: return $signed($urandom_range(32'h1ffff)) - 32'sh10000;
            default: return $signed($urandom_range(32'h3fffff)) - 32'sh200000;
        endcase
    endfunction

    function automatic logic [30:0] rand_uns();
        case ($urandom_range(9))
            0: return 31'($urandom());
            1: return $urandom_range(1) ? 31'h7fffffff : 31'd0;
            2, 3: return 31'($urandom_range(32'h1ffff));
            default: return 31'($urandom_range(32'h3fff));
        endcase
    endfunction

    function automatic ebsb_pkg::body_req_t rand_body();
        ebsb_pkg::body_req_t r;
        r.force_x = rand_word();
        r.force_y = rand_word();
        r.vel_in_x = rand_word();
        r.vel_in_y = rand_word();
        r.pos_in_x = rand_word();
        r.pos_in_y = rand_word();
        r.body_mass = rand_uns();
        if (r.body_mass == 0 && $urandom_range(1))
            r.body_mass = 31'h10000;
        r.friction_coef = rand_uns();
        r.delta_t = rand_uns();
        return r;
    endfunction

    function automatic ebsb_pkg::body_req_t make_body(input logic [31:0] f,
                                                      input logic [31:0] v,
                                                      input logic [31:0] p,
                                                      input logic [30:0] m,
                                                      input logic [30:0] fr,
                                                      input logic [30:0] dt);
        ebsb_pkg::body_req_t r;
        r.force_x = f;
        r.force_y = -f;
        r.vel_in_x = v;
        r.vel_in_y = v;
        r.pos_in_x = p;
        r.pos_in_y = -p;
        r.body_mass = m;
        r.friction_coef = fr;
        r.delta_t = dt;
        return r;
    endfunction

    // Appends one request to the pending list.
    task automatic queue_body(input ebsb_pkg::body_req_t r);
        pending_requests = {pending_requests, r};
    endtask

    // Directed bodies: field extremes, zero mass, saturation and bound crossings.
    task automatic add_directed();
        queue_body(make_body(0, 0, 0, 31'h10000, 31'd0, 31'd0));
        queue_body(make_body(32'h10000, 32'h10000, 32'h20000,
                             31'h10000, 31'h1000, 31'h1000));
        queue_body(make_body(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
        queue_body(make_body(32'h80000000, 32'h80000000, 32'h80000000,
                             31'd1, 31'h7fffffff, 31'h7fffffff));
        queue_body(make_body(32'h12345, 0, 0, 31'd0, 31'h100, 31'h100));
        queue_body(make_body(32'hfff00000, 32'h50000, 32'h40000,
                             31'd0, 31'd0, 31'h8000));
        queue_body(make_body(32'h80000000, 32'h7fffffff, 32'h7fff0000,
                             31'd1, 31'd0, 31'd1));
        queue_body(make_body(0, 32'hffff0000, 32'hfff00000, 31'd5,
                             31'h7fffffff, 31'd0));
        queue_body(make_body(32'h00300000, 32'hffd00000, 32'h00100000,
                             31'h20000, 31'h4000, 31'h4000));
        queue_body(make_body(32'hffff_ffff, 32'd1, 32'hffff_ffff,
                             31'h7fffffff, 31'd1, 31'd1));
    endtask

    task automatic add_random(input int count);
        repeat (count) queue_body(rand_body());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        lim_min_x = 0;
        lim_min_y = 0;
        lim_max_x = 0;
        lim_max_y = 0;
        wrap_mode = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset bounds (all zero, clamp) first.
        add_directed();
        wait_idle();

        // Moderate bounds, clamping.
        set_bounds(32'hfff00000, 32'hffe00000, 32'h00100000, 32'h00200000, 1'b0);
        add_directed();
        add_random(250);
        wait_idle();

        // Same bounds, wrapping; let traffic build, then pause until all is back.
        write_reg(ebsb_pkg::REG_WRAP, 32'd1);
        add_random(150);
        while (pending_requests.size() > 75)
            @(posedge clk);
        sender_hold = 1'b1;
        while (expected_bodies.size() > 0 || in_valid)
            @(posedge clk);
        sender_hold = 1'b0;
        add_random(150);
        wait_idle();

        // Full-range bounds, and a stretch without any idling.
        set_bounds(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0);
        quiet_mode = 1'b1;
        add_random(200);
        wait_idle();
        quiet_mode = 1'b0;

        // Inverted bounds: the max check may undo the min check.
        set_bounds(32'h00100000, 32'h7fffffff, 32'hfff00000, 32'h80000000, 1'b1);
        add_directed();
        add_random(200);
        wait_idle();
        write_reg(ebsb_pkg::REG_WRAP, 32'd0);
        add_random(150);
        wait_idle();

        // Tight bounds at the extremes, wrapping.
        set_bounds(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1);
        add_random(150);
        wait_idle();

        if (mismatch_count == 0 && expected_bodies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far longer than the slowest correct run.
    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
